>>> design/renc_pkg.sv
// ----------------------------------------------------------------------------
// renc_pkg
// Shared types and constants for the rotary encoder position tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package renc_pkg;

	localparam int unsigned PosW   = 32;
	localparam int unsigned TimeW  = 32;
	localparam int unsigned StepW  = 8;
	localparam int unsigned WinW   = 16;
	localparam int unsigned CfgW   = 32;
	localparam int unsigned CfgIdxW = 3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_MIN_POSITION    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_POSITION    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_STEP_NORMAL     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_STEP_FAST       = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_STEP_SHIFT      = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_WRAP_ENABLE     = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_PRESS_WINDOW_MS = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_FAST_WINDOW_MS  = 3'd7;

	// item function codes
	localparam logic FUNC_EDGE  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic                    func;
		logic [TimeW-1:0]        time_ms;
		logic                    level_a;
		logic                    level_b;
		logic                    shift_held;
		logic signed [PosW-1:0]  new_position;
	} item_t;

	typedef struct packed {
		logic signed [PosW-1:0]  position;
		logic                    stepped;
		logic                    write_ok;
	} result_t;

	typedef struct packed {
		logic signed [PosW-1:0]  min_position;
		logic signed [PosW-1:0]  max_position;
		logic [StepW-1:0]        step_normal;
		logic [StepW-1:0]        step_fast;
		logic [StepW-1:0]        step_shift;
		logic                    wrap_enable;
		logic [WinW-1:0]         press_window_ms;
		logic [WinW-1:0]         fast_window_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [PosW-1:0]  position;
		logic [TimeW-1:0]        press_start;
		logic                    press_pending;
		logic                    direction;
		logic [TimeW-1:0]        last_step_time;
	} track_t;

endpackage

`default_nettype wire

>>> design/renc_cfg.sv
// ----------------------------------------------------------------------------
// renc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module renc_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [renc_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [renc_pkg::CfgW-1:0]        cfg_wdata,
	output renc_pkg::cfg_t                        cfg
);

	renc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_position    <= 32'sd0;
			cfg_q.max_position    <= 32'sd100;
			cfg_q.step_normal     <= 8'd1;
			cfg_q.step_fast       <= 8'd1;
			cfg_q.step_shift      <= 8'd1;
			cfg_q.wrap_enable     <= 1'b0;
			cfg_q.press_window_ms <= 16'd50;
			cfg_q.fast_window_ms  <= 16'd300;
		end else if (cfg_we) begin
			case (cfg_index)
				renc_pkg::REG_MIN_POSITION:    cfg_q.min_position    <= cfg_wdata;
				renc_pkg::REG_MAX_POSITION:    cfg_q.max_position    <= cfg_wdata;
				renc_pkg::REG_STEP_NORMAL:     cfg_q.step_normal     <= cfg_wdata[7:0];
				renc_pkg::REG_STEP_FAST:       cfg_q.step_fast       <= cfg_wdata[7:0];
				renc_pkg::REG_STEP_SHIFT:      cfg_q.step_shift      <= cfg_wdata[7:0];
				renc_pkg::REG_WRAP_ENABLE:     cfg_q.wrap_enable     <= cfg_wdata[0];
				renc_pkg::REG_PRESS_WINDOW_MS: cfg_q.press_window_ms <= cfg_wdata[15:0];
				renc_pkg::REG_FAST_WINDOW_MS:  cfg_q.fast_window_ms  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/renc_core.sv
// ----------------------------------------------------------------------------
// renc_core
// Single-pass update of the tracker state and result for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module renc_core (
	input  wire renc_pkg::item_t  item,
	input  wire renc_pkg::cfg_t   cfg,
	input  wire renc_pkg::track_t cur,
	output renc_pkg::track_t      nxt,
	output renc_pkg::result_t     res
);

	logic [renc_pkg::TimeW-1:0] press_age;
	logic [renc_pkg::TimeW-1:0] step_gap;
	logic                       stale;
	logic                       short_pulse;
	logic                       fast;
	logic [renc_pkg::StepW-1:0] inc;
	logic signed [renc_pkg::PosW:0] pos_ext;
	logic signed [renc_pkg::PosW:0] min_ext;
	logic signed [renc_pkg::PosW:0] max_ext;
	logic signed [renc_pkg::PosW:0] inc_ext;
	logic signed [renc_pkg::PosW:0] sum;
	logic signed [renc_pkg::PosW:0] hi_fix;
	logic signed [renc_pkg::PosW:0] lo_fix;
	logic                       in_range;

	// time differences wrap modulo 2^32
	assign press_age   = item.time_ms - cur.press_start;
	assign step_gap    = item.time_ms - cur.last_step_time;
	assign stale       = press_age > {16'd0, cfg.press_window_ms};
	assign short_pulse = press_age < {16'd0, cfg.press_window_ms};
	assign fast        = step_gap < {16'd0, cfg.fast_window_ms};

	always_comb begin
		if (item.shift_held) begin
			inc = cfg.step_shift;
		end else if (fast) begin
			inc = cfg.step_fast;
		end else begin
			inc = cfg.step_normal;
		end
	end

	assign pos_ext = {cur.position[renc_pkg::PosW-1], cur.position};
	assign min_ext = {cfg.min_position[renc_pkg::PosW-1], cfg.min_position};
	assign max_ext = {cfg.max_position[renc_pkg::PosW-1], cfg.max_position};
	assign inc_ext = $signed({25'd0, inc});
	assign sum     = cur.direction ? (pos_ext - inc_ext) : (pos_ext + inc_ext);

	// upper limit first, then lower limit on the corrected value
	always_comb begin
		if (sum > max_ext) begin
			hi_fix = cfg.wrap_enable ? min_ext : max_ext;
		end else begin
			hi_fix = sum;
		end
		if (hi_fix < min_ext) begin
			lo_fix = cfg.wrap_enable ? max_ext : min_ext;
		end else begin
			lo_fix = hi_fix;
		end
	end

	assign in_range = (item.new_position >= cfg.min_position)
		&& (item.new_position <= cfg.max_position);

	always_comb begin
		nxt = cur;
		res.stepped  = 1'b0;
		res.write_ok = 1'b0;
		if (item.func == renc_pkg::FUNC_WRITE) begin
			if (in_range) begin
				nxt.position = item.new_position;
				res.write_ok = 1'b1;
			end
		end else if (!item.level_a) begin
			if (!cur.press_pending || stale) begin
				nxt.press_start   = item.time_ms;
				nxt.press_pending = 1'b1;
				nxt.direction     = item.level_b;
			end
		end else if (cur.press_pending) begin
			if (short_pulse) begin
				nxt.last_step_time = item.time_ms;
				nxt.position       = lo_fix[renc_pkg::PosW-1:0];
				res.stepped        = 1'b1;
			end
			nxt.press_pending = 1'b0;
		end
		res.position = nxt.position;
	end

endmodule

`default_nettype wire

>>> design/rotary_encoder_position_tracker.sv
// ----------------------------------------------------------------------------
// rotary_encoder_position_tracker
// Tracks encoder position from channel A edge events, with fast and shift
// increments, clamp or wrap at the limits, and position writes.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+---------------------------
//  item     | item_valid / item_ready     | item   (renc_pkg::item_t)
//  result   | result_valid / result_ready | result (renc_pkg::result_t)
//  config   | cfg_we                      | cfg_index, cfg_wdata
//
//  one transaction per cycle sustained unless the result channel stalls;
//  items pass the input register, then the result register
//  the tracker state is updated in the same pass that forms the result
//  a stalled result register holds the input register; an empty input
//  register still takes one more transaction while the result waits
//  reset clears position and press state and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_position_tracker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire renc_pkg::item_t              item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output renc_pkg::result_t                 result,
	input  wire logic                         cfg_we,
	input  wire logic [renc_pkg::CfgIdxW-1:0] cfg_index,
	input  wire logic [renc_pkg::CfgW-1:0]    cfg_wdata
);

	renc_pkg::cfg_t    cfg;
	renc_pkg::item_t   item_s1;
	logic              valid_s1;
	renc_pkg::result_t result_s2;
	logic              valid_s2;
	renc_pkg::track_t  track_q;
	renc_pkg::track_t  track_nxt;
	renc_pkg::result_t res_nxt;
	logic              advance;

	renc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	renc_core u_core (
		.item (item_s1),
		.cfg  (cfg),
		.cur  (track_q),
		.nxt  (track_nxt),
		.res  (res_nxt)
	);

	// stage 1 moves into the result register when that is free or drained
	assign advance    = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			track_q  <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					track_q <= track_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance && valid_s1) begin
			result_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef ASSERT_OFF
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.stepped && result.write_ok))
		else $error("stepped and write_ok both set");

	a_fill_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> result_valid)
		else $error("processed transaction produced no result");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(track_q))
		else $error("tracker state changed while stalled");

	a_pos_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1) |=> (result.position == track_q.position))
		else $error("result position differs from tracked position");
`endif

endmodule

`default_nettype wire

>>> tb/rotary_encoder_position_tracker_tb.sv
// ----------------------------------------------------------------------------
// rotary_encoder_position_tracker_tb
// Self-checking bench for the encoder tracker. A queue-fed driver sends edge
// events and position writes with random gaps. A receiver stalls the result
// channel at random. Each accepted transaction is run through a local
// tracker model, and every result is compared field by field. The register
// settings change between phases: reset values, narrow wrapping limits, full
// 32-bit limits with clamp and wrap, inverted limits, a zero press window,
// time stamps that wrap, and random settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rotary_encoder_position_tracker_tb;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         item_valid;
	logic                         item_ready;
	renc_pkg::item_t              item;
	logic                         result_valid;
	logic                         result_ready;
	renc_pkg::result_t            result;
	logic                         cfg_we;
	logic [renc_pkg::CfgIdxW-1:0] cfg_index;
	logic [renc_pkg::CfgW-1:0]    cfg_wdata;

	renc_pkg::item_t   pending_items[$];
	renc_pkg::result_t expected_results[$];
	renc_pkg::cfg_t    regs;
	renc_pkg::track_t  tracker;
	logic [31:0] now_ms;
	int unsigned items_sent, items_taken, results_taken, results_seen;
	int unsigned send_gap, rcv_stall;
	int unsigned errors;
	bit          calm;

	rotary_encoder_position_tracker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #2 clk = ~clk;

	// position after one item, updating the local tracker state
	function automatic renc_pkg::result_t track_encoder(input renc_pkg::item_t it);
		renc_pkg::result_t r;
		logic [31:0] held;
		logic [31:0] since_step;
		logic [7:0]  inc;
		longint      sum;
		r = '0;
		held = it.time_ms - tracker.press_start;
		since_step = it.time_ms - tracker.last_step_time;
		if (it.func == renc_pkg::FUNC_WRITE) begin
			if ($signed(it.new_position) >= $signed(regs.min_position) &&
			    $signed(it.new_position) <= $signed(regs.max_position)) begin
				tracker.position = it.new_position;
				r.write_ok = 1'b1;
			end
		end else if (!it.level_a) begin
			if (!tracker.press_pending || held > {16'd0, regs.press_window_ms}) begin
				tracker.press_start = it.time_ms;
				tracker.press_pending = 1'b1;
				tracker.direction = it.level_b;
			end
		end else if (tracker.press_pending) begin
			if (held < {16'd0, regs.press_window_ms}) begin
				inc = (since_step < {16'd0, regs.fast_window_ms}) ? regs.step_fast
					: regs.step_normal;
				tracker.last_step_time = it.time_ms;
				if (it.shift_held)
					inc = regs.step_shift;
				sum = longint'($signed(tracker.position));
				sum = tracker.direction ? sum - longint'(inc) : sum + longint'(inc);
				// upper limit first, then lower, at full precision
				if (sum > longint'($signed(regs.max_position)))
					sum = regs.wrap_enable ? longint'($signed(regs.min_position))
						: longint'($signed(regs.max_position));
				if (sum < longint'($signed(regs.min_position)))
					sum = regs.wrap_enable ? longint'($signed(regs.max_position))
						: longint'($signed(regs.min_position));
				tracker.position = sum[31:0];
				r.stepped = 1'b1;
			end
			tracker.press_pending = 1'b0;
		end
		r.position = tracker.position;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic renc_pkg::item_t mk_item(input logic f, input logic [31:0] t,
			input logic a, input logic b, input logic sh, input logic [31:0] np);
		renc_pkg::item_t it;
		it.func = f;
		it.time_ms = t;
		it.level_a = a;
		it.level_b = b;
		it.shift_held = sh;
		it.new_position = np;
		return it;
	endfunction

	function automatic renc_pkg::cfg_t make_cfg(input logic [31:0] lo,
			input logic [31:0] hi,
			input int unsigned sn, input int unsigned sf, input int unsigned ss,
			input int unsigned wrap, input int unsigned press, input int unsigned fast);
		renc_pkg::cfg_t c;
		c.min_position = lo;
		c.max_position = hi;
		c.step_normal = sn[7:0];
		c.step_fast = sf[7:0];
		c.step_shift = ss[7:0];
		c.wrap_enable = wrap[0];
		c.press_window_ms = press[15:0];
		c.fast_window_ms = fast[15:0];
		return c;
	endfunction

	// random position between the limits, or anything when they are inverted
	function automatic logic [31:0] in_range_pos();
		longint          lo;
		longint          hi;
		longint unsigned off;
		lo = longint'($signed(regs.min_position));
		hi = longint'($signed(regs.max_position));
		if (lo > hi)
			return $urandom;
		off = {$urandom, $urandom};
		off = off % (hi - lo + 1);
		return 32'(lo + off);
	endfunction

	task automatic push_edge(input logic [31:0] t, input logic a, input logic b,
			input logic sh);
		pending_items.push_back(mk_item(renc_pkg::FUNC_EDGE, t, a, b, sh, $urandom));
	endtask

	task automatic push_write(input logic [31:0] np);
		pending_items.push_back(mk_item(renc_pkg::FUNC_WRITE, $urandom,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), np));
	endtask

	// falling edge after gap, rising edge after pulse
	task automatic push_detent(input logic b, input logic sh, input int unsigned pulse,
			input int unsigned gap);
		now_ms += gap;
		push_edge(now_ms, 1'b0, b, 1'($urandom_range(0, 1)));
		now_ms += pulse;
		push_edge(now_ms, 1'b1, 1'($urandom_range(0, 1)), sh);
	endtask

	task automatic gen_random(input int n);
		int          made;
		int unsigned pick;
		int unsigned press;
		int unsigned pulse;
		made = 0;
		press = 32'(regs.press_window_ms);
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				pulse = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * press + 2)
					: $urandom_range(0, press);
				push_detent(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, pulse,
					$urandom_range(0, 2 * regs.fast_window_ms + 2));
				made += 2;
			end else if (pick < 80) begin
				push_write(in_range_pos());
				made++;
			end else if (pick < 85) begin
				push_write($urandom);
				made++;
			end else if (pick < 95) begin
				// lone edge: stray rise, repeated fall
				now_ms += $urandom_range(0, 20);
				push_edge(now_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				made++;
			end else begin
				pending_items.push_back(mk_item(1'($urandom_range(0, 1)), $urandom,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom));
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic [renc_pkg::CfgIdxW-1:0] idx,
			input logic [renc_pkg::CfgW-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
	endtask

	task automatic program_regs(input renc_pkg::cfg_t c);
		write_reg(renc_pkg::REG_MIN_POSITION, c.min_position);
		write_reg(renc_pkg::REG_MAX_POSITION, c.max_position);
		write_reg(renc_pkg::REG_STEP_NORMAL, renc_pkg::CfgW'(c.step_normal));
		write_reg(renc_pkg::REG_STEP_FAST, renc_pkg::CfgW'(c.step_fast));
		write_reg(renc_pkg::REG_STEP_SHIFT, renc_pkg::CfgW'(c.step_shift));
		write_reg(renc_pkg::REG_WRAP_ENABLE, renc_pkg::CfgW'(c.wrap_enable));
		write_reg(renc_pkg::REG_PRESS_WINDOW_MS, renc_pkg::CfgW'(c.press_window_ms));
		write_reg(renc_pkg::REG_FAST_WINDOW_MS, renc_pkg::CfgW'(c.fast_window_ms));
		@(negedge clk);
		cfg_we = 1'b0;
		regs = c;
	endtask

	// sender holds off until every expected result is back
	task automatic drain();
		while (pending_items.size() != 0 || items_sent != items_taken ||
		       expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_valid && items_taken == items_sent)
				item_valid = 1'b0;
			if (!item_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_items.size() != 0) begin
					item = pending_items.pop_front();
					item_valid = 1'b1;
					items_sent++;
					send_gap = pick_gap();
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (results_seen != results_taken) begin
				results_seen = results_taken;
				rcv_stall = pick_gap();
			end
			if (rcv_stall != 0) begin
				result_ready = 1'b0;
				rcv_stall--;
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	// monitor: predict on each input transaction, check each result transaction
	always @(posedge clk) begin : monitor
		renc_pkg::result_t want;
		if (arst_n && item_valid && item_ready) begin
			expected_results.push_back(track_encoder(item));
			items_taken++;
		end
		if (arst_n && result_valid && result_ready) begin
			results_taken++;
			if (expected_results.size() == 0) begin
				$error("result transaction with no expectation waiting");
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (result.position !== want.position) begin
					$error("position: expected %0d, got %0d", $signed(want.position),
						$signed(result.position));
					errors++;
				end
				if (result.stepped !== want.stepped) begin
					$error("stepped: expected %0b, got %0b", want.stepped, result.stepped);
					errors++;
				end
				if (result.write_ok !== want.write_ok) begin
					$error("write_ok: expected %0b, got %0b", want.write_ok,
						result.write_ok);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [31:0] lo_pos;
		logic [31:0] hi_pos;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		items_sent = 0;
		items_taken = 0;
		results_taken = 0;
		results_seen = 0;
		send_gap = 0;
		rcv_stall = 0;
		errors = 0;
		calm = 1'b0;
		regs = make_cfg(32'd0, 32'd100, 1, 1, 1, 0, 50, 300);
		tracker = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// register defaults: write limits, stray rise, fresh and stale falls
		now_ms = 32'd1000;
		push_write(32'd50);
		push_write(32'd101);
		push_write(32'hFFFF_FFFF);
		push_write(32'd100);
		push_write(32'd0);
		push_edge(now_ms, 1'b1, 1'b0, 1'b0);
		now_ms += 10;
		push_edge(now_ms, 1'b0, 1'b0, 1'b0);
		now_ms += 5;
		push_edge(now_ms, 1'b0, 1'b1, 1'b0);
		now_ms += 5;
		push_edge(now_ms, 1'b1, 1'b1, 1'b0);
		push_detent(1'b1, 1'b0, 50, 400);
		now_ms += 10;
		push_edge(now_ms, 1'b0, 1'b1, 1'b0);
		now_ms += 100;
		push_edge(now_ms, 1'b0, 1'b0, 1'b0);
		now_ms += 5;
		push_edge(now_ms, 1'b1, 1'b0, 1'b0);
		push_detent(1'b1, 1'b1, 10, 10);
		push_write(32'd100);
		push_detent(1'b0, 1'b0, 1, 1000);
		gen_random(90);
		drain();

		// narrow limits with wrap, distinct normal, fast and shift steps
		program_regs(make_cfg(-32'sd20, 32'sd20, 3, 7, 11, 1, 40, 200));
		push_write(32'd0);
		push_detent(1'b0, 1'b0, 5, 1000);
		push_detent(1'b0, 1'b0, 5, 50);
		push_detent(1'b0, 1'b1, 5, 50);
		push_detent(1'b1, 1'b0, 5, 1000);
		gen_random(110);
		drain();

		// full 32-bit limits, wrap, widest windows
		program_regs(make_cfg(32'h8000_0000, 32'h7FFF_FFFF, 255, 255, 255, 1, 65535, 65535));
		push_write(32'h7FFF_FFFF);
		push_detent(1'b0, 1'b0, 10, 100000);
		push_detent(1'b1, 1'b1, 10, 10);
		gen_random(90);
		drain();

		// full limits with clamp, zero normal step, no fast detents
		program_regs(make_cfg(32'h8000_0000, 32'h7FFF_FFFF, 0, 128, 255, 0, 65535, 0));
		push_write(32'h7FFF_FFFF);
		push_detent(1'b0, 1'b1, 10, 10);
		push_write(32'h8000_0000);
		push_detent(1'b1, 1'b0, 10, 10);
		push_detent(1'b1, 1'b1, 10, 10);
		gen_random(80);
		drain();

		// inverted limits, wrap then clamp
		program_regs(make_cfg(32'sd50, -32'sd50, 5, 9, 13, 1, 100, 400));
		gen_random(60);
		drain();
		program_regs(make_cfg(32'sd50, -32'sd50, 5, 9, 13, 0, 100, 400));
		gen_random(40);
		drain();

		// zero press window: no pulse is short enough
		program_regs(make_cfg(-32'sd100, 32'sd100, 1, 2, 3, 0, 0, 65535));
		gen_random(30);
		drain();

		// time stamps run through the 32-bit wrap, back to back transactions
		calm = 1'b1;
		now_ms = 32'hFFFF_FC00;
		program_regs(make_cfg(-32'sd1000, 32'sd1000, 4, 16, 64, 0, 100, 500));
		gen_random(150);
		drain();
		calm = 1'b0;

		repeat (3) begin
			lo_pos = $urandom_range(0, 2000) - 1000;
			hi_pos = lo_pos + $urandom_range(0, 2000);
			if ($urandom_range(0, 3) == 0) begin
				lo_pos = $urandom;
				hi_pos = $urandom;
			end
			program_regs(make_cfg(lo_pos, hi_pos, $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
				$urandom_range(1, 300), $urandom_range(0, 1500)));
			gen_random(90);
			drain();
		end

		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("** rotary_encoder_position_tracker: PASSED **");
		else
			$display("** rotary_encoder_position_tracker: FAILED **");
		$finish;
	end

	initial begin
		#2000000;
		$display("** rotary_encoder_position_tracker: FAILED **");
		$finish;
	end

endmodule
